// ===== src/segmented_lookup_sum_unit_defines.svh =====
// Assertion macros used by the checker file of the lookup sum unit.
`ifndef SEGMENTED_LOOKUP_SUM_UNIT_DEFINES_SVH
`define SEGMENTED_LOOKUP_SUM_UNIT_DEFINES_SVH

// Same-cycle implication, off during reset.
`define SLS_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sls assertion failed");

// Next-cycle implication, off during reset.
`define SLS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sls assertion failed");

`endif

// ===== src/sls_pkg.sv =====
// Shared constants, codes and types of the lookup sum unit.
package sls_pkg;

  localparam int LANES         = 4;
  localparam int ELEMENT_BITS  = 16;
  localparam int ROW_BITS      = LANES * ELEMENT_BITS;
  localparam int TABLE_DEPTH   = 1024;
  localparam int ADDR_BITS     = $clog2(TABLE_DEPTH);
  localparam int MAX_SEGMENTS  = 64;
  localparam int SUM_BITS      = 22;
  localparam int INDEX_BITS    = 16;
  localparam int SEG_CFG_BITS  = 7;
  localparam int EPS_CFG_BITS  = 11;
  localparam int CFG_DATA_BITS = 11;

  typedef enum logic {
    CFG_SEGMENTS            = 1'b0,
    CFG_ENTRIES_PER_SEGMENT = 1'b1
  } cfg_index_t;

  typedef enum logic {
    OP_WRITE  = 1'b0,
    OP_LOOKUP = 1'b1
  } op_t;

  // Per-cycle lane control from the sequencer.
  typedef struct packed {
    logic clear;  // drop partial sums
    logic acc;    // add the row lane this cycle
    logic last;   // closing segment of a group
  } lane_ctrl_t;

endpackage

// ===== src/sls_if.sv =====
// Request, response and configuration channel interfaces.
interface sls_req_if import sls_pkg::*; ();
  logic                         valid;
  logic                         ready;
  op_t                          operation;
  logic [ADDR_BITS-1:0]         write_row;
  logic [ROW_BITS-1:0]          row_data;
  logic signed [INDEX_BITS-1:0] stored_index;

  modport source (output valid, operation, write_row, row_data, stored_index,
                  input ready);
  modport sink   (input valid, operation, write_row, row_data, stored_index,
                  output ready);
endinterface

interface sls_rsp_if import sls_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [SUM_BITS-1:0] sum_lane0;
  logic signed [SUM_BITS-1:0] sum_lane1;
  logic signed [SUM_BITS-1:0] sum_lane2;
  logic signed [SUM_BITS-1:0] sum_lane3;

  modport source (output valid, sum_lane0, sum_lane1, sum_lane2, sum_lane3,
                  input ready);
  modport sink   (input valid, sum_lane0, sum_lane1, sum_lane2, sum_lane3,
                  output ready);
endinterface

interface sls_cfg_if import sls_pkg::*; ();
  logic                     valid;
  logic                     ready;
  cfg_index_t               index;
  logic [CFG_DATA_BITS-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== src/sls_table.sv =====
// Row table: one write port, one read port with registered read data.
module sls_table import sls_pkg::*; (
  input  logic                 clk,
  input  logic                 wr_en,
  input  logic [ADDR_BITS-1:0] wr_addr,
  input  logic [ROW_BITS-1:0]  wr_data,
  input  logic                 rd_en,
  input  logic [ADDR_BITS-1:0] rd_addr,
  output logic [ROW_BITS-1:0]  rd_data
);

  logic [ROW_BITS-1:0] mem [TABLE_DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== src/sls_lane.sv =====
// One lane: sign-extends its element and keeps the running sum.
module sls_lane import sls_pkg::*; (
  input  logic                       clk,
  input  logic                       rst,
  input  lane_ctrl_t                 ctrl,
  input  logic [ELEMENT_BITS-1:0]    element,
  output logic signed [SUM_BITS-1:0] total
);

  logic signed [SUM_BITS-1:0] sum;

  // total wraps at SUM_BITS
  assign total = sum + SUM_BITS'(signed'(element));

  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      sum <= '0;
    end else if (ctrl.acc) begin
      sum <= ctrl.last ? '0 : total;
    end
  end

endmodule

// ===== src/segmented_lookup_sum_unit.sv =====
// Top level of the segmented lookup sum unit.
//
//  channel | dir | handshake    | payload
//  --------+-----+--------------+------------------------------------------
//  req     | in  | valid/ready  | operation, write_row, row_data, stored_index
//  rsp     | out | valid/ready  | sum_lane0..sum_lane3
//  cfg     | in  | valid/ready  | index, data (segments, rows per segment)
//
// One request per cycle while req.ready is high; the row table read port sets the pace.
// Closing lookup: row read into the table read reg, then lane add and capture in the result reg.
// Write requests take the table write port and never produce a response.
// rst is synchronous; sums, segment position, base and valids clear.
// A closing lookup waits in the read stage while the result reg is full and rsp.ready is low;
// req.ready is low for that time. cfg is always ready; a write restarts the group.
module segmented_lookup_sum_unit import sls_pkg::*; #(
  parameter int SEGMENT_LIMIT = MAX_SEGMENTS
) (
  input  logic        clk,
  input  logic        rst,
  sls_req_if.sink     req,
  sls_rsp_if.source   rsp,
  sls_cfg_if.sink     cfg
);

  localparam int POS_BITS  = (SEGMENT_LIMIT > 1) ? $clog2(SEGMENT_LIMIT) : 1;
  localparam int SEGC_BITS = $clog2(SEGMENT_LIMIT + 1);

  // Effective (clamped) configuration
  logic [SEGC_BITS-1:0]    seg_eff;
  logic [EPS_CFG_BITS-1:0] eps_eff;

  // Group sequencing
  logic [POS_BITS-1:0]  pos;
  logic [ADDR_BITS-1:0] base;

  // Read stage
  logic s1_valid;
  logic s1_last;
  logic s1_advance;

  // Result register
  logic                       out_valid;
  logic signed [SUM_BITS-1:0] out_sum [LANES];
  logic                       out_free;

  logic cfg_wr;
  logic req_acc;
  logic lookup_acc;
  logic write_acc;

  logic [INDEX_BITS-1:0]  idx_u;
  logic [ADDR_BITS-1:0]   idx0;
  logic [ADDR_BITS-1:0]   rd_addr;
  logic [SEGC_BITS:0]     pos_inc;
  logic                   lookup_last;
  logic [ROW_BITS-1:0]    rd_data;

  lane_ctrl_t                 lane_ctrl;
  logic signed [SUM_BITS-1:0] lane_total [LANES];

  assign cfg.ready = 1'b1;
  assign cfg_wr    = cfg.valid && cfg.ready;

  assign out_free   = !out_valid || rsp.ready;
  assign s1_advance = !(s1_valid && s1_last) || out_free;
  assign req.ready  = s1_advance;

  assign req_acc    = req.valid && req.ready;
  assign lookup_acc = req_acc && (req.operation == OP_LOOKUP);
  assign write_acc  = req_acc && (req.operation == OP_WRITE);

  // Clamp the one-based index to 1..eps and make it zero-based.
  assign idx_u = req.stored_index;
  always_comb begin
    if (idx_u[INDEX_BITS-1] || idx_u == '0) begin
      idx0 = '0;
    end else if (idx_u >= INDEX_BITS'(eps_eff)) begin
      idx0 = ADDR_BITS'(eps_eff - 1'b1);
    end else begin
      idx0 = ADDR_BITS'(idx_u - 1'b1);
    end
  end

  // Row address wraps modulo table depth.
  assign rd_addr     = base + idx0;
  assign pos_inc     = (SEGC_BITS + 1)'(pos) + 1'b1;
  assign lookup_last = pos_inc >= (SEGC_BITS + 1)'(seg_eff);

  // Configuration, clamped on write
  always_ff @(posedge clk) begin
    if (rst) begin
      seg_eff <= SEGC_BITS'(1);
      eps_eff <= EPS_CFG_BITS'(1);
    end else if (cfg_wr) begin
      case (cfg.index)
        CFG_SEGMENTS: begin
          if (cfg.data[SEG_CFG_BITS-1:0] == '0) begin
            seg_eff <= SEGC_BITS'(1);
          end else if (cfg.data[SEG_CFG_BITS-1:0] > SEGMENT_LIMIT) begin
            seg_eff <= SEGC_BITS'(SEGMENT_LIMIT);
          end else begin
            seg_eff <= SEGC_BITS'(cfg.data[SEG_CFG_BITS-1:0]);
          end
        end
        CFG_ENTRIES_PER_SEGMENT: begin
          if (cfg.data == '0) begin
            eps_eff <= EPS_CFG_BITS'(1);
          end else if (cfg.data > TABLE_DEPTH) begin
            eps_eff <= EPS_CFG_BITS'(TABLE_DEPTH);
          end else begin
            eps_eff <= cfg.data;
          end
        end
        default: begin
          eps_eff <= eps_eff;
        end
      endcase
    end
  end

  // Segment position and base advance as each lookup is accepted.
  always_ff @(posedge clk) begin
    if (rst || cfg_wr) begin
      pos  <= '0;
      base <= '0;
    end else if (lookup_acc) begin
      if (lookup_last) begin
        pos  <= '0;
        base <= '0;
      end else begin
        pos  <= pos + 1'b1;
        base <= base + ADDR_BITS'(eps_eff);
      end
    end
  end

  sls_table u_table (
    .clk     (clk),
    .wr_en   (write_acc),
    .wr_addr (req.write_row),
    .wr_data (req.row_data),
    .rd_en   (lookup_acc),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Read stage tracks the row in flight; holds only when closing and blocked.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s1_last  <= 1'b0;
    end else if (s1_advance) begin
      s1_valid <= lookup_acc;
      s1_last  <= lookup_last;
    end
  end

  assign lane_ctrl.clear = cfg_wr;
  assign lane_ctrl.acc   = s1_valid && s1_advance;
  assign lane_ctrl.last  = s1_last;

  for (genvar l = 0; l < LANES; l++) begin : g_lane
    sls_lane u_lane (
      .clk     (clk),
      .rst     (rst),
      .ctrl    (lane_ctrl),
      .element (rd_data[l*ELEMENT_BITS +: ELEMENT_BITS]),
      .total   (lane_total[l])
    );
  end

  // Merge: capture all lane totals when a group closes.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (lane_ctrl.acc && lane_ctrl.last) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (lane_ctrl.acc && lane_ctrl.last) begin
      out_sum <= lane_total;
    end
  end

  assign rsp.valid     = out_valid;
  assign rsp.sum_lane0 = out_sum[0];
  assign rsp.sum_lane1 = out_sum[1];
  assign rsp.sum_lane2 = out_sum[2];
  assign rsp.sum_lane3 = out_sum[3];

endmodule

// ===== src/sls_checker.sv =====
// Port-level checker of the lookup sum unit and its bind.
`include "segmented_lookup_sum_unit_defines.svh"

module sls_checker import sls_pkg::*; (
  input logic                       clk,
  input logic                       rst,
  input logic                       req_valid,
  input logic                       req_ready,
  input op_t                        req_operation,
  input logic                       rsp_valid,
  input logic                       rsp_ready,
  input logic signed [SUM_BITS-1:0] sum_lane0,
  input logic signed [SUM_BITS-1:0] sum_lane1,
  input logic signed [SUM_BITS-1:0] sum_lane2,
  input logic signed [SUM_BITS-1:0] sum_lane3
);

  // requests back up only behind a blocked response
  `SLS_ASSERT_IMP(a_ready_low_blocked, clk, rst, !req_ready, rsp_valid && !rsp_ready)

  // a new response traces back to an accepted lookup request
  `SLS_ASSERT_IMP(a_rsp_from_lookup, clk, rst, $rose(rsp_valid), $past(req_valid && req_ready && req_operation == OP_LOOKUP, 2))

  `SLS_ASSERT_NEXT(a_rsp_hold, clk, rst, rsp_valid && !rsp_ready, rsp_valid)

  `SLS_ASSERT_NEXT(a_rsp_stable, clk, rst, rsp_valid && !rsp_ready, $stable(sum_lane0) && $stable(sum_lane1) && $stable(sum_lane2) && $stable(sum_lane3))

endmodule

bind segmented_lookup_sum_unit sls_checker u_sls_checker (
  .clk           (clk),
  .rst           (rst),
  .req_valid     (req.valid),
  .req_ready     (req.ready),
  .req_operation (req.operation),
  .rsp_valid     (rsp.valid),
  .rsp_ready     (rsp.ready),
  .sum_lane0     (rsp.sum_lane0),
  .sum_lane1     (rsp.sum_lane1),
  .sum_lane2     (rsp.sum_lane2),
  .sum_lane3     (rsp.sum_lane3)
);

// ===== bench/segmented_lookup_sum_unit_tb.sv =====
// Self-checking bench for the segmented lookup sum unit: directed corners, random groups.
`timescale 1ns / 100ps

import sls_pkg::*;

// One request as seen on the req channel.
typedef struct {
  op_t                          operation;
  logic [ADDR_BITS-1:0]         write_row;
  logic [ROW_BITS-1:0]          row_data;
  logic signed [INDEX_BITS-1:0] stored_index;
} table_request_t;

// Four lane sums, lane 0 in the low slot.
typedef logic [LANES-1:0][SUM_BITS-1:0] lane_sums_t;

// Shadow of the unit: table, group sums, registers and the sums still owed.
class lookup_sum_tracker;
  logic [ROW_BITS-1:0]     rows [TABLE_DEPTH];
  bit                      loaded [TABLE_DEPTH];
  lane_sums_t              running;
  int unsigned             position;
  int unsigned             base;
  logic [SEG_CFG_BITS-1:0] seg_reg;
  logic [EPS_CFG_BITS-1:0] eps_reg;
  lane_sums_t              owed_sums [$];
  int unsigned             mismatches;

  function new();
    seg_reg    = SEG_CFG_BITS'(1);
    eps_reg    = EPS_CFG_BITS'(1);
    mismatches = 0;
    clear_group();
  endfunction

  function void clear_group();
    running  = '0;
    position = 0;
    base     = 0;
  endfunction

  function int unsigned active_segments();
    if (seg_reg == 0) return 1;
    if (seg_reg > MAX_SEGMENTS) return MAX_SEGMENTS;
    return 32'(seg_reg);
  endfunction

  function int unsigned active_entries();
    if (eps_reg == 0) return 1;
    if (eps_reg > TABLE_DEPTH) return TABLE_DEPTH;
    return 32'(eps_reg);
  endfunction

  // Row that a lookup with this index hits in the current segment.
  function logic [ADDR_BITS-1:0] row_for(logic signed [INDEX_BITS-1:0] idx);
    int k;
    int e;
    e = active_entries();
    k = int'(idx);
    if (k < 1) k = 1;
    if (k > e) k = e;
    return ADDR_BITS'((base + k - 1) % TABLE_DEPTH);
  endfunction

  function bit is_loaded(logic [ADDR_BITS-1:0] addr);
    return loaded[addr];
  endfunction

  function int unsigned pending();
    return owed_sums.size();
  endfunction

  function void note_config(cfg_index_t idx, logic [CFG_DATA_BITS-1:0] value);
    if (idx == CFG_SEGMENTS) seg_reg = value[SEG_CFG_BITS-1:0];
    else eps_reg = value[EPS_CFG_BITS-1:0];
    clear_group();
  endfunction

  function void note_request(table_request_t r);
    logic [ADDR_BITS-1:0]           addr;
    logic [ROW_BITS-1:0]            data;
    logic signed [ELEMENT_BITS-1:0] elem;
    if (r.operation == OP_WRITE) begin
      rows[r.write_row]   = r.row_data;
      loaded[r.write_row] = 1'b1;
      return;
    end
    addr = row_for(r.stored_index);
    data = rows[addr];
    for (int l = 0; l < LANES; l++) begin
      elem = data[l*ELEMENT_BITS +: ELEMENT_BITS];
      running[l] = running[l] + {{(SUM_BITS-ELEMENT_BITS){elem[ELEMENT_BITS-1]}}, elem};
    end
    if (position + 1 >= active_segments()) begin
      owed_sums.push_back(running);
      clear_group();
    end else begin
      position++;
      base = (base + active_entries()) % TABLE_DEPTH;
    end
  endfunction

  function void check_sums(lane_sums_t got);
    lane_sums_t want;
    if (owed_sums.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("unexpected result: lanes %0d %0d %0d %0d", $signed(got[0]),
                 $signed(got[1]), $signed(got[2]), $signed(got[3]));
      return;
    end
    want = owed_sums.pop_front();
    for (int l = 0; l < LANES; l++) begin
      if (got[l] !== want[l]) begin
        mismatches++;
        if (mismatches <= 10)
          $display("sum_lane%0d: expected %0d, got %0d", l, $signed(want[l]),
                   $signed(got[l]));
      end
    end
  endfunction
endclass

module segmented_lookup_sum_unit_tb;

  // Cycles left after the last owed sum before a register write or the end:
  // covers table read and lane add of a non-closing lookup.
  localparam int DRAIN_CYCLES  = 8;
  localparam int RANDOM_PHASES = 8;
  localparam int PHASE_ITEMS   = 154;

  logic clk;
  logic rst;

  sls_req_if req ();
  sls_rsp_if rsp ();
  sls_cfg_if cfg ();

  segmented_lookup_sum_unit dut (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp),
    .cfg (cfg)
  );

  lookup_sum_tracker sb = new();

  // Idle percentages of the current phase, request side and result side.
  int send_idle_pct;
  int stall_pct;

  // Requests accepted so far, preload writes included.
  int unsigned sent_count = 0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #1000000;
    $display("FAIL");
    $finish;
  end

  // Result side: random backpressure, every accepted result checked in order.
  initial begin
    rsp.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && rsp.valid && rsp.ready)
        sb.check_sums({rsp.sum_lane3, rsp.sum_lane2, rsp.sum_lane1, rsp.sum_lane0});
      rsp.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  function automatic void set_mode(int m);
    case (m)
      0:       begin send_idle_pct = 0;  stall_pct = 0;  end
      1:       begin send_idle_pct = 84; stall_pct = 0;  end
      2:       begin send_idle_pct = 0;  stall_pct = 84; end
      default: begin send_idle_pct = 30; stall_pct = 30; end
    endcase
  endfunction

  // Random lanes, now and then forced to the lane extremes.
  function automatic logic [ROW_BITS-1:0] random_row();
    logic [ROW_BITS-1:0] r;
    r = {$urandom, $urandom};
    if ($urandom_range(3) == 0) begin
      for (int l = 0; l < LANES; l++) begin
        case ($urandom_range(3))
          0:       r[l*ELEMENT_BITS +: ELEMENT_BITS] = 16'h7fff;
          1:       r[l*ELEMENT_BITS +: ELEMENT_BITS] = 16'h8000;
          2:       r[l*ELEMENT_BITS +: ELEMENT_BITS] = 16'h0000;
          default: r[l*ELEMENT_BITS +: ELEMENT_BITS] = 16'hffff;
        endcase
      end
    end
    return r;
  endfunction

  // Mostly in-range indices; some raw 16-bit values and clamp edges.
  function automatic logic signed [INDEX_BITS-1:0] random_index(int unsigned e);
    logic signed [INDEX_BITS-1:0] idx;
    case ($urandom_range(9))
      0: idx = INDEX_BITS'($urandom);
      1: begin
        case ($urandom_range(4))
          0:       idx = 16'sh8000;
          1:       idx = 16'sh0000;
          2:       idx = 16'sh7fff;
          3:       idx = INDEX_BITS'(e);
          default: idx = INDEX_BITS'(e + 1);
        endcase
      end
      default: idx = INDEX_BITS'($urandom_range(e, 1));
    endcase
    return idx;
  endfunction

  // Drive one request, with random idle cycles ahead of it; valid stays
  // high after acceptance so back-to-back requests need no second update.
  task automatic send(table_request_t r);
    while ($urandom_range(99) < send_idle_pct) begin
      req.valid <= 1'b0;
      @(posedge clk);
    end
    req.valid        <= 1'b1;
    req.operation    <= r.operation;
    req.write_row    <= r.write_row;
    req.row_data     <= r.row_data;
    req.stored_index <= r.stored_index;
    do @(posedge clk); while (!req.ready);
    sb.note_request(r);
    sent_count++;
  endtask

  // Unused fields carry random values so they are seen to be ignored.
  task automatic write_item(logic [ADDR_BITS-1:0] addr, logic [ROW_BITS-1:0] data);
    table_request_t r;
    r.operation    = OP_WRITE;
    r.write_row    = addr;
    r.row_data     = data;
    r.stored_index = INDEX_BITS'($urandom);
    send(r);
  endtask

  // A row is never read before it is written: load it first if needed.
  task automatic lookup_item(logic signed [INDEX_BITS-1:0] idx);
    table_request_t       r;
    logic [ADDR_BITS-1:0] addr;
    addr = sb.row_for(idx);
    if (!sb.is_loaded(addr)) write_item(addr, random_row());
    r.operation    = OP_LOOKUP;
    r.write_row    = ADDR_BITS'($urandom);
    r.row_data     = {$urandom, $urandom};
    r.stored_index = idx;
    send(r);
  endtask

  task automatic random_item();
    if ($urandom_range(99) < 15)
      write_item(ADDR_BITS'($urandom_range(TABLE_DEPTH - 1)), random_row());
    else
      lookup_item(random_index(sb.active_entries()));
  endtask

  // Drop valid, wait for every owed sum, then let the pipeline empty.
  task automatic settle();
    req.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Both registers, back to back; only called with the unit idle.
  task automatic configure(logic [CFG_DATA_BITS-1:0] seg_val,
                           logic [CFG_DATA_BITS-1:0] eps_val);
    cfg.valid <= 1'b1;
    cfg.index <= CFG_SEGMENTS;
    cfg.data  <= seg_val;
    do @(posedge clk); while (!cfg.ready);
    sb.note_config(CFG_SEGMENTS, seg_val);
    cfg.index <= CFG_ENTRIES_PER_SEGMENT;
    cfg.data  <= eps_val;
    do @(posedge clk); while (!cfg.ready);
    sb.note_config(CFG_ENTRIES_PER_SEGMENT, eps_val);
    cfg.valid <= 1'b0;
  endtask

  initial begin
    logic [CFG_DATA_BITS-1:0] seg_val;
    logic [CFG_DATA_BITS-1:0] eps_val;
    int unsigned              phase_start;

    set_mode(0);
    rst              <= 1'b1;
    req.valid        <= 1'b0;
    req.operation    <= OP_WRITE;
    req.write_row    <= '0;
    req.row_data     <= '0;
    req.stored_index <= '0;
    cfg.valid        <= 1'b0;
    cfg.index        <= CFG_SEGMENTS;
    cfg.data         <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // --- directed ---
    // Reset registers: one segment of one row, so every index clamps to row 0.
    write_item(ADDR_BITS'(0), 64'h0000_ffff_8000_7fff);
    lookup_item(16'sh0001);
    lookup_item(16'sh8000);
    lookup_item(16'sh7fff);
    lookup_item(16'sh0000);
    write_item(ADDR_BITS'(TABLE_DEPTH - 1), 64'h8000_8000_8000_8000);
    write_item(ADDR_BITS'(1), 64'hffff_ffff_ffff_ffff);

    // Out-of-range registers: zero segments acts as one, all-ones entries
    // acts as the full table depth.
    settle();
    configure(11'd0, 11'h7ff);
    lookup_item(16'sh7fff);
    lookup_item(16'sh0002);

    // Three segments of 400 rows overrun the table; the last segment wraps.
    // A table write lands in the middle of the group and must not disturb it.
    settle();
    configure(11'd3, 11'd400);
    lookup_item(-16'sd5);
    write_item(ADDR_BITS'(5), random_row());
    lookup_item(16'sd400);
    lookup_item(16'sd400);

    // Register write mid-group abandons the partial sums.
    lookup_item(16'sd1);
    settle();
    configure(11'd2, 11'd1);
    lookup_item(16'sd1);
    lookup_item(16'sd7);

    // --- random ---
    // Phase pairs share an idling mode; the first two phases hold the largest
    // settings (all-ones register data, then the exact upper limits).
    for (int k = 0; k < RANDOM_PHASES; k++) begin
      set_mode(k / 2);
      settle();
      if (k == 0) begin
        seg_val = 11'h7ff;
        eps_val = 11'h7ff;
      end else if (k == 1) begin
        seg_val = CFG_DATA_BITS'(MAX_SEGMENTS);
        eps_val = CFG_DATA_BITS'(TABLE_DEPTH);
      end else begin
        case ($urandom_range(7))
          0:       seg_val = '0;
          1:       seg_val = CFG_DATA_BITS'($urandom);
          default: seg_val = CFG_DATA_BITS'($urandom_range(6, 1));
        endcase
        case ($urandom_range(7))
          0:       eps_val = '0;
          1:       eps_val = CFG_DATA_BITS'($urandom);
          2:       eps_val = CFG_DATA_BITS'($urandom_range(TABLE_DEPTH, 1));
          default: eps_val = CFG_DATA_BITS'($urandom_range(16, 1));
        endcase
      end
      configure(seg_val, eps_val);
      phase_start = sent_count;
      while (sent_count - phase_start < PHASE_ITEMS) random_item();
    end

    settle();
    if (sb.mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
